// ===== rtl/vtge_pkg.sv =====
// vtge_pkg: shared types and constants for the vector tile geometry encoder
// used by vtge_varint_unit and vector_tile_geometry_encoder; no dependencies

package vtge_pkg;

	// field widths
	localparam int unsigned COORD_W = 32;
	localparam int unsigned COUNT_W = 29;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned GROUP_W = 7;

	// stream payload widths
	localparam int unsigned IN_DATA_W = 96;
	localparam int unsigned IN_USER_W = 4;

	// command ids
	localparam logic [2:0] CMD_MOVE_TO = 3'h1;
	localparam logic [2:0] CMD_LINE_TO = 3'h2;
	localparam logic [2:0] CMD_CLOSE   = 3'h7;

	// part kinds
	localparam logic [KIND_W-1:0] KIND_POINTS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LINE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RING   = 2'd2;

	// saturation value of the vertex index
	localparam logic [COUNT_W-1:0] IDX_MAX = {COUNT_W{1'b1}};

	// load request into the varint unit
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] value;
		logic              last;
	} vtge_ld_t;

	// command word: id in the low three bits, count above
	function automatic logic [WORD_W-1:0] cmd_word(input logic [2:0] id,
		input logic [COUNT_W-1:0] count);
		cmd_word = {count, id};
	endfunction

	// zigzag mapping of a 32-bit two's complement delta
	function automatic logic [WORD_W-1:0] zigzag(input logic [COORD_W-1:0] d);
		zigzag = {d[COORD_W-2:0], 1'b0} ^ {COORD_W{d[COORD_W-1]}};
	endfunction

endpackage

// ===== rtl/vtge_varint_unit.sv =====
// vtge_varint_unit: shared shift unit that sends one 32-bit word as varint bytes
// uses vtge_pkg; holds the output register of the byte stream

module vtge_varint_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vtge_pkg::vtge_ld_t           ld,
	output logic                         ld_ready,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [vtge_pkg::BYTE_W-1:0]  m_axis_tdata,   // out_byte [7:0]
	output logic                         m_axis_tlast    // last_byte
);

	logic                        active_q;
	logic                        last_q;
	logic [vtge_pkg::WORD_W-1:0] val_q;
	logic                        tvalid_q;
	logic                        tlast_q;
	logic [vtge_pkg::BYTE_W-1:0] tdata_q;
	logic                        more;
	logic                        emit;

	// more groups follow when any bit above the low group is set
	assign more     = |val_q[vtge_pkg::WORD_W-1:vtge_pkg::GROUP_W];
	assign emit     = active_q && (!tvalid_q || m_axis_tready);
	assign ld_ready = !active_q;

	// shift register and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				tvalid_q <= 1'b1;
				if (!more)
					active_q <= 1'b0;
			end else if (tvalid_q && m_axis_tready) begin
				tvalid_q <= 1'b0;
			end
			if (ld.valid && !active_q)
				active_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (emit) begin
			tdata_q <= {more, val_q[vtge_pkg::GROUP_W-1:0]};
			tlast_q <= last_q && !more;
			val_q   <= val_q >> vtge_pkg::GROUP_W;
		end
		if (ld.valid && !active_q) begin
			val_q  <= ld.value;
			last_q <= ld.last;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tlast  = tlast_q;

endmodule

// ===== rtl/vector_tile_geometry_encoder.sv =====
// vector_tile_geometry_encoder: top level, vertex decode and field sequencer
// uses vtge_pkg and vtge_varint_unit
// usage:
//   s_axis carries one vertex per item: tdata holds coord_x, coord_y and
//   part_points, tuser holds part_kind, part_start and geom_start.
//   m_axis carries the command stream one byte per item; tlast marks the
//   last byte that a vertex causes. a vertex that gives no bytes shows nothing.
// sequencing:
//   a vertex is taken, then each of up to three varint words
//   (command, x delta, y delta) goes to the shared shift unit in turn; the
//   unit sends one byte per cycle while m_axis_tready is high and takes a
//   new word only after the last byte of its previous word has gone into
//   the output register. the first byte passes the vertex registers, the
//   shift register and the output register. s_axis_tready is high while the
//   sequencer is idle.
// reset: arst_n clears the cursor, the vertex index, the sequencer and the
//   valid flag of the output register; no byte is pending afterwards.
// stall: when m_axis_tready is low the byte in the output register holds,
//   the shift unit waits, and the sequencer stops taking vertices once it
//   needs the unit.

module vector_tile_geometry_encoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// coord_x [31:0], coord_y [63:32], part_points [92:64], zero [95:93]
	input  logic [vtge_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// part_kind [1:0], part_start [2], geom_start [3]
	input  logic [vtge_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// out_byte [7:0]
	output logic [vtge_pkg::BYTE_W-1:0]     m_axis_tdata,
	// last_byte
	output logic                            m_axis_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMD  = 2'd1;
	localparam logic [1:0] ST_DX   = 2'd2;
	localparam logic [1:0] ST_DY   = 2'd3;

	logic [1:0]                     state_q;
	logic [vtge_pkg::COORD_W-1:0]   cur_x_q;
	logic [vtge_pkg::COORD_W-1:0]   cur_y_q;
	logic [vtge_pkg::COUNT_W-1:0]   vidx_q;
	logic [vtge_pkg::COORD_W-1:0]   x_q;
	logic [vtge_pkg::COORD_W-1:0]   y_q;
	logic [vtge_pkg::WORD_W-1:0]    cmd_q;
	logic                           pt_q;

	logic [vtge_pkg::COORD_W-1:0]   in_x;
	logic [vtge_pkg::COORD_W-1:0]   in_y;
	logic [vtge_pkg::COUNT_W-1:0]   in_npts;
	logic [vtge_pkg::KIND_W-1:0]    in_kind;
	logic                           in_pstart;
	logic                           in_gstart;

	logic                           accept;
	logic [vtge_pkg::COUNT_W-1:0]   idx;
	logic [vtge_pkg::COUNT_W-1:0]   limit;
	logic [vtge_pkg::COUNT_W:0]     idx_p1;
	logic                           has_cmd;
	logic                           has_pt;
	logic [vtge_pkg::WORD_W-1:0]    cmd_sel;

	logic [vtge_pkg::COORD_W-1:0]   sub_a;
	logic [vtge_pkg::COORD_W-1:0]   sub_b;
	logic [vtge_pkg::COORD_W-1:0]   delta;
	vtge_pkg::vtge_ld_t             ld;
	logic                           ld_ready;

	// unpack the vertex
	assign in_x      = s_axis_tdata[31:0];
	assign in_y      = s_axis_tdata[63:32];
	assign in_npts   = s_axis_tdata[92:64];
	assign in_kind   = s_axis_tuser[1:0];
	assign in_pstart = s_axis_tuser[2];
	assign in_gstart = s_axis_tuser[3];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// vertex decode: which words this vertex gives
	always_comb begin
		idx     = in_pstart ? '0 : vidx_q;
		idx_p1  = {1'b0, idx} + 1'b1;
		limit   = in_npts;
		has_cmd = 1'b0;
		has_pt  = 1'b0;
		cmd_sel = vtge_pkg::cmd_word(vtge_pkg::CMD_MOVE_TO, in_npts);
		if (in_kind == vtge_pkg::KIND_RING)
			limit = (in_npts != '0) ? in_npts - 1'b1 : '0;
		case (in_kind)
			vtge_pkg::KIND_POINTS: begin
				if (idx < in_npts) begin
					has_pt  = 1'b1;
					has_cmd = (idx == '0);
				end
			end
			vtge_pkg::KIND_LINE, vtge_pkg::KIND_RING: begin
				if (limit != '0) begin
					if (idx < limit) begin
						has_pt = 1'b1;
						if (idx == '0) begin
							has_cmd = 1'b1;
							cmd_sel = vtge_pkg::cmd_word(vtge_pkg::CMD_MOVE_TO,
								vtge_pkg::COUNT_W'(1));
						end else if (idx == vtge_pkg::COUNT_W'(1)) begin
							has_cmd = 1'b1;
							cmd_sel = vtge_pkg::cmd_word(vtge_pkg::CMD_LINE_TO,
								limit - 1'b1);
						end
					end else if (in_kind == vtge_pkg::KIND_RING && idx == limit) begin
						has_cmd = 1'b1;
						cmd_sel = vtge_pkg::cmd_word(vtge_pkg::CMD_CLOSE,
							vtge_pkg::COUNT_W'(1));
					end
				end
			end
			default: begin
				has_cmd = 1'b0;
				has_pt  = 1'b0;
			end
		endcase
	end

	// shared subtractor for the x and y deltas
	assign sub_a = (state_q == ST_DY) ? y_q : x_q;
	assign sub_b = (state_q == ST_DY) ? cur_y_q : cur_x_q;
	assign delta = sub_a - sub_b;

	// load request into the shift unit
	always_comb begin
		ld.valid = 1'b0;
		ld.value = cmd_q;
		ld.last  = !pt_q;
		case (state_q)
			ST_CMD: begin
				ld.valid = 1'b1;
			end
			ST_DX, ST_DY: begin
				ld.valid = 1'b1;
				ld.value = vtge_pkg::zigzag(delta);
				ld.last  = (state_q == ST_DY);
			end
			default: begin
				ld.valid = 1'b0;
			end
		endcase
	end

	// sequencer, cursor and vertex index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_x_q <= '0;
			cur_y_q <= '0;
			vidx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_gstart) begin
							cur_x_q <= '0;
							cur_y_q <= '0;
						end
						vidx_q <= (idx == vtge_pkg::IDX_MAX) ? vtge_pkg::IDX_MAX :
							idx_p1[vtge_pkg::COUNT_W-1:0];
						if (has_cmd)
							state_q <= ST_CMD;
						else if (has_pt)
							state_q <= ST_DX;
					end
				end
				ST_CMD: begin
					if (ld_ready)
						state_q <= pt_q ? ST_DX : ST_IDLE;
				end
				ST_DX: begin
					if (ld_ready)
						state_q <= ST_DY;
				end
				ST_DY: begin
					if (ld_ready) begin
						cur_x_q <= x_q;
						cur_y_q <= y_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// vertex payload
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= in_x;
			y_q   <= in_y;
			cmd_q <= cmd_sel;
			pt_q  <= has_pt;
		end
	end

	vtge_varint_unit u_varint (
		.clk           (clk),
		.arst_n        (arst_n),
		.ld            (ld),
		.ld_ready      (ld_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

`ifndef SYNTHESIS
	// the last byte of a word never carries the continuation bit
	a_last_no_more: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[7])
		else $error("last byte has continuation bit set");

	// the cursor takes the vertex once its y delta is handed over
	a_cursor_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DY) && ld_ready |=> (cur_x_q == $past(x_q)) &&
			(cur_y_q == $past(y_q)))
		else $error("cursor not updated after point");

	// no vertex is taken while a word is still to be handed over
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ld.valid |-> !s_axis_tready)
		else $error("vertex accepted while sequencer busy");
`endif

endmodule
